>>> hdl/gcd_pkg.sv
// Shared types and constants for the genome compatibility distance block.
package gcd_pkg;

   // Field widths fixed by the data format
   localparam int WORD_W      = 16;
   localparam int DIST_W      = 24;
   localparam int CSR_INDEX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_EXCESS_COEFF   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISJOINT_COEFF = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_COEFF   = 2'd2;

   // Configuration reset values (unsigned Q8.8)
   localparam logic [WORD_W-1:0] EXCESS_COEFF_RST   = 16'd256;
   localparam logic [WORD_W-1:0] DISJOINT_COEFF_RST = 16'd256;
   localparam logic [WORD_W-1:0] WEIGHT_COEFF_RST   = 16'd102;

   // Largest distance value before clipping
   localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

   // Input beat kinds
   typedef enum logic [1:0] {
      MODE_LOAD_FIRST  = 2'd0,
      MODE_LOAD_SECOND = 2'd1,
      MODE_COMPUTE     = 2'd2,
      MODE_UNUSED      = 2'd3
   } mode_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_WALK,
      ST_MUL_EXC,
      ST_MUL_DIS,
      ST_MUL_WGT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic wr_first;
      logic wr_second;
      logic capture_group;
      logic walk_clear;
      logic walk_step;
      logic mul_exc;
      logic mul_dis;
      logic mul_wgt;
      logic div_start;
      logic finish;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic walk_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

>>> hdl/gcd_ctrl.sv
// Controller state machine: sequences loads, the merge walk, products and division.
module gcd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_mode,
   input  gcd_pkg::status_type status,
   output gcd_pkg::cmd_type    cmd
);
   import gcd_pkg::*;

   state_type state_ff;
   state_type state_in;
   mode_type  mode;
   logic      accept;

   assign mode   = mode_type'(req_mode);
   assign accept = req_tvalid && req_tready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && mode == MODE_COMPUTE) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP:      state_in = ST_WALK;
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_MUL_EXC;
            end
         end
         ST_MUL_EXC:   state_in = ST_MUL_DIS;
         ST_MUL_DIS:   state_in = ST_MUL_WGT;
         ST_MUL_WGT:   state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               unique case (mode)
                  MODE_LOAD_FIRST:  cmd.wr_first      = 1'b1;
                  MODE_LOAD_SECOND: cmd.wr_second     = 1'b1;
                  MODE_COMPUTE:     cmd.capture_group = 1'b1;
                  default:          ;
               endcase
            end
         end
         ST_PREP:      cmd.walk_clear = 1'b1;
         ST_WALK:      cmd.walk_step  = !status.walk_done;
         ST_MUL_EXC:   cmd.mul_exc    = 1'b1;
         ST_MUL_DIS:   cmd.mul_dis    = 1'b1;
         ST_MUL_WGT:   cmd.mul_wgt    = 1'b1;
         ST_DIV_START: cmd.div_start  = 1'b1;
         ST_DIV_WAIT:  ;
         ST_FINISH:    cmd.finish     = status.out_free;
         default:      ;
      endcase
   end

endmodule

>>> hdl/gcd_div.sv
// Restoring divider: one quotient bit per cycle, 16-bit divisor.
module gcd_div #(
   parameter int NUM_W = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [NUM_W-1:0]          numerator,
   input  logic [gcd_pkg::WORD_W-1:0] divisor,
   output logic                      done,
   output logic [NUM_W-1:0]          quotient
);
   import gcd_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  work_ff;
   logic [WORD_W-1:0] rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;
   logic              fits;

   // Trial subtract of the divisor from the shifted remainder
   assign shifted = {rem_ff, work_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign fits    = shifted >= {1'b0, divisor};

   // Control: busy until every numerator bit is done, done pulses after the last bit
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Dividend shifts out on top, quotient bits shift in at the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= numerator;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         work_ff <= {work_ff[NUM_W-2:0], fits};
         rem_ff  <= fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

>>> hdl/gcd_datapath.sv
// Datapath: gene stores, merge-walk registers, shared multiplier, divider and result register.
module gcd_datapath #(
   parameter int MAX_GENES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gcd_pkg::cmd_type                cmd,
   output gcd_pkg::status_type             status,
   input  logic [gcd_pkg::WORD_W-1:0]      req_innovation,
   input  logic [gcd_pkg::WORD_W-1:0]      req_gene_weight,
   input  logic [gcd_pkg::WORD_W-1:0]      req_group_size,
   input  logic                            csr_we,
   input  logic [gcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gcd_pkg::WORD_W-1:0]      csr_wdata,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [6:0]                      rsp_excess_count,
   output logic [7:0]                      rsp_disjoint_count,
   output logic [gcd_pkg::WORD_W-1:0]      rsp_weight_diff_avg,
   output logic [gcd_pkg::DIST_W-1:0]      rsp_distance,
   output logic                            rsp_saturated
);
   import gcd_pkg::*;

   localparam int CNT_W  = $clog2(MAX_GENES + 1);
   localparam int ADDR_W = $clog2(MAX_GENES);
   localparam int DIS_W  = $clog2(2 * MAX_GENES + 1);
   localparam int NUM_W  = WORD_W + DIS_W + 1;
   localparam int TOT_W  = ((NUM_W > DIST_W) ? NUM_W : DIST_W) + 1;
   localparam int PROD_W = 2 * WORD_W;

   // Configuration
   logic [WORD_W-1:0] excess_coeff_ff;
   logic [WORD_W-1:0] disjoint_coeff_ff;
   logic [WORD_W-1:0] weight_coeff_ff;

   // Stores and fill counts
   logic [2*WORD_W-1:0] first_mem  [MAX_GENES];
   logic [2*WORD_W-1:0] second_mem [MAX_GENES];
   logic [CNT_W-1:0]    first_count_ff;
   logic [CNT_W-1:0]    second_count_ff;
   logic                first_full;
   logic                second_full;

   // Walk state
   logic [CNT_W-1:0]    i1_ff, i1_in;
   logic [CNT_W-1:0]    i2_ff, i2_in;
   logic [DIS_W-1:0]    disj_ff, disj_in;
   logic [WORD_W-1:0]   avg_ff, avg_in;
   logic [ADDR_W-1:0]   rd1_addr;
   logic [ADDR_W-1:0]   rd2_addr;
   logic [2*WORD_W-1:0] first_rd_ff;
   logic [2*WORD_W-1:0] second_rd_ff;
   logic [WORD_W-1:0]   inn_a, inn_b;
   logic [WORD_W:0]     wdiff;
   logic [WORD_W:0]     wdiff_abs;
   logic [WORD_W:0]     avg_sum;
   logic                walk_done;
   logic [CNT_W-1:0]    excess;

   // Arithmetic
   logic [WORD_W-1:0]   group_ff;
   logic [CNT_W-1:0]    excess_ff;
   logic [WORD_W-1:0]   mul_a;
   logic [WORD_W-1:0]   mul_b;
   logic [PROD_W-1:0]   prod_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [DIST_W-1:0]   wterm_ff;
   logic                div_done;
   logic [NUM_W-1:0]    quotient;
   logic [TOT_W-1:0]    total;
   logic                sat;
   logic [CNT_W+7:0]    excess_wide;
   logic [DIS_W+7:0]    disj_wide;

   // Result register
   logic                rsp_valid_ff;
   logic                out_free;
   logic [6:0]          out_excess_ff;
   logic [7:0]          out_disjoint_ff;
   logic [WORD_W-1:0]   out_avg_ff;
   logic [DIST_W-1:0]   out_distance_ff;
   logic                out_saturated_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         excess_coeff_ff   <= EXCESS_COEFF_RST;
         disjoint_coeff_ff <= DISJOINT_COEFF_RST;
         weight_coeff_ff   <= WEIGHT_COEFF_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EXCESS_COEFF:   excess_coeff_ff   <= csr_wdata;
            CSR_DISJOINT_COEFF: disjoint_coeff_ff <= csr_wdata;
            CSR_WEIGHT_COEFF:   weight_coeff_ff   <= csr_wdata;
            default:            ;
         endcase
      end
   end

   assign first_full  = first_count_ff == CNT_W'(MAX_GENES);
   assign second_full = second_count_ff == CNT_W'(MAX_GENES);

   // Fill counts: bump on load, clear when a compute finishes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
      end else if (cmd.finish) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
      end else begin
         if (cmd.wr_first && !first_full) begin
            first_count_ff <= first_count_ff + CNT_W'(1);
         end
         if (cmd.wr_second && !second_full) begin
            second_count_ff <= second_count_ff + CNT_W'(1);
         end
      end
   end

   // Gene stores: innovation low, weight high; read at the next walk index
   always_ff @(posedge clock) begin
      if (cmd.wr_first && !first_full) begin
         first_mem[first_count_ff[ADDR_W-1:0]] <= {req_gene_weight, req_innovation};
      end
      first_rd_ff <= first_mem[rd1_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_second && !second_full) begin
         second_mem[second_count_ff[ADDR_W-1:0]] <= {req_gene_weight, req_innovation};
      end
      second_rd_ff <= second_mem[rd2_addr];
   end

   assign rd1_addr = (i1_in < CNT_W'(MAX_GENES)) ? i1_in[ADDR_W-1:0] : '0;
   assign rd2_addr = (i2_in < CNT_W'(MAX_GENES)) ? i2_in[ADDR_W-1:0] : '0;

   // One merge step per cycle
   assign inn_a     = first_rd_ff[WORD_W-1:0];
   assign inn_b     = second_rd_ff[WORD_W-1:0];
   assign wdiff     = {first_rd_ff[2*WORD_W-1], first_rd_ff[2*WORD_W-1:WORD_W]}
                    - {second_rd_ff[2*WORD_W-1], second_rd_ff[2*WORD_W-1:WORD_W]};
   assign wdiff_abs = wdiff[WORD_W] ? (~wdiff + (WORD_W+1)'(1)) : wdiff;
   assign avg_sum   = wdiff_abs + {1'b0, avg_ff};
   assign walk_done = (i1_ff >= first_count_ff) || (i2_ff >= second_count_ff);
   assign excess    = (i1_ff < first_count_ff) ? (first_count_ff - i1_ff)
                                               : (second_count_ff - i2_ff);

   always_comb begin
      i1_in   = i1_ff;
      i2_in   = i2_ff;
      disj_in = disj_ff;
      avg_in  = avg_ff;
      if (cmd.walk_clear) begin
         i1_in   = '0;
         i2_in   = '0;
         disj_in = '0;
         avg_in  = '0;
      end else if (cmd.walk_step) begin
         if (inn_a == inn_b) begin
            avg_in = (avg_ff == '0) ? wdiff_abs[WORD_W-1:0] : avg_sum[WORD_W:1];
            i1_in  = i1_ff + CNT_W'(1);
            i2_in  = i2_ff + CNT_W'(1);
         end else if (inn_a < inn_b) begin
            disj_in = disj_ff + DIS_W'(1);
            i1_in   = i1_ff + CNT_W'(1);
         end else begin
            disj_in = disj_ff + DIS_W'(1);
            i2_in   = i2_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i1_ff   <= '0;
         i2_ff   <= '0;
         disj_ff <= '0;
         avg_ff  <= '0;
      end else begin
         i1_ff   <= i1_in;
         i2_ff   <= i2_in;
         disj_ff <= disj_in;
         avg_ff  <= avg_in;
      end
   end

   // Group size, zero taken as one
   always_ff @(posedge clock) begin
      if (cmd.capture_group) begin
         group_ff <= (req_group_size == '0) ? WORD_W'(1) : req_group_size;
      end
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.mul_exc) begin
         mul_a = excess_coeff_ff;
         mul_b = WORD_W'(excess);
      end else if (cmd.mul_dis) begin
         mul_a = disjoint_coeff_ff;
         mul_b = WORD_W'(disj_ff);
      end else if (cmd.mul_wgt) begin
         mul_a = weight_coeff_ff;
         mul_b = avg_ff;
      end
   end

   // Products, numerator accumulation and weight term
   always_ff @(posedge clock) begin
      if (cmd.mul_exc || cmd.mul_dis || cmd.mul_wgt) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.mul_exc) begin
         excess_ff <= excess;
      end
      if (cmd.mul_dis) begin
         num_ff <= NUM_W'(prod_ff);
      end else if (cmd.mul_wgt) begin
         num_ff <= num_ff + NUM_W'(prod_ff);
      end
      if (cmd.div_start) begin
         wterm_ff <= prod_ff[PROD_W-1:8];
      end
   end

   gcd_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .numerator (num_ff),
      .divisor   (group_ff),
      .done      (div_done),
      .quotient  (quotient)
   );

   // Final sum and clipping
   assign total       = TOT_W'(quotient) + TOT_W'(wterm_ff);
   assign sat         = |total[TOT_W-1:DIST_W];
   assign excess_wide = {8'd0, excess_ff};
   assign disj_wide   = {8'd0, disj_ff};

   // Result register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_excess_ff    <= excess_wide[6:0];
         out_disjoint_ff  <= disj_wide[7:0];
         out_avg_ff       <= avg_ff;
         out_distance_ff  <= sat ? DIST_MAX : total[DIST_W-1:0];
         out_saturated_ff <= sat;
      end
   end

   assign rsp_tvalid          = rsp_valid_ff;
   assign rsp_excess_count    = out_excess_ff;
   assign rsp_disjoint_count  = out_disjoint_ff;
   assign rsp_weight_diff_avg = out_avg_ff;
   assign rsp_distance        = out_distance_ff;
   assign rsp_saturated       = out_saturated_ff;
   assign status.walk_done    = walk_done;
   assign status.div_done     = div_done;
   assign status.out_free     = out_free;

   // A walk step only happens with both indices inside their lists
   a_step_in_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (i1_ff < first_count_ff && i2_ff < second_count_ff))
      else $error("walk step past the end of a gene list");

   // Each disjoint gene consumed one index
   a_disjoint_bound: assert property (@(posedge clock) disable iff (reset)
      (DIS_W+1)'(disj_ff) <= ((DIS_W+1)'(i1_ff) + (DIS_W+1)'(i2_ff)))
      else $error("disjoint count exceeds genes walked");

   // A pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   // Stores are empty right after a result is produced
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (first_count_ff == '0 && second_count_ff == '0))
      else $error("gene stores not emptied after compute");

endmodule

>>> hdl/genome_compatibility_distance.sv
// Top level of the genome compatibility distance block.
// Genes are loaded one beat per cycle into two stores of MAX_GENES entries each (extra genes
// are dropped); a compute beat merge-walks both stores at one gene step per cycle, then forms
// (c1*excess + c2*disjoint)/n + c3*avg through one shared multiplier and a one-bit-per-cycle
// divider. The walk takes at most n1 + n2 gene steps, and the divider yields one quotient bit
// for each of the NUM_W = 17 + clog2(2*MAX_GENES+1) numerator bits (25 at 64 genes); the walk
// and the divider set the compute time. No new beat is taken during a compute; a finished
// result waits in the output register while loads for the next pair are already accepted.
module genome_compatibility_distance #(
   parameter int MAX_GENES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // innovation, gene_weight, group_size
   input  logic [1:0]  req_tuser,   // mode
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // excess_count, disjoint_count, weight_diff_avg,
                                    // distance, zero pad
   output logic        rsp_tuser,   // saturated
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import gcd_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic [6:0]        excess_count;
   logic [7:0]        disjoint_count;
   logic [WORD_W-1:0] weight_diff_avg;
   logic [DIST_W-1:0] distance;

   gcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   gcd_datapath #(
      .MAX_GENES (MAX_GENES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_innovation      (req_tdata[15:0]),
      .req_gene_weight     (req_tdata[31:16]),
      .req_group_size      (req_tdata[47:32]),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_tready          (rsp_tready),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_excess_count    (excess_count),
      .rsp_disjoint_count  (disjoint_count),
      .rsp_weight_diff_avg (weight_diff_avg),
      .rsp_distance        (distance),
      .rsp_saturated       (rsp_tuser)
   );

   // Pack result fields, lowest first
   assign rsp_tdata = {1'b0, distance, weight_diff_avg, disjoint_count, excess_count};

endmodule

>>> dv/genome_compatibility_distance_tb.sv
// Testbench for the genome compatibility distance block: gene loads, merge-walk results, CSRs.
module genome_compatibility_distance_tb;
   import gcd_pkg::*;

   localparam int MAX_GENES     = 64;
   localparam int SETTLE_CYCLES = 200;   // longer than one full compute
   localparam int ITEM_TARGET   = 1650;

   typedef struct {
      mode_type          mode;
      logic [WORD_W-1:0] innovation;
      logic [WORD_W-1:0] gene_weight;
      logic [WORD_W-1:0] group_size;
   } gene_beat_type;

   typedef struct {
      logic [6:0]        excess_count;
      logic [7:0]        disjoint_count;
      logic [WORD_W-1:0] weight_diff_avg;
      logic [DIST_W-1:0] distance;
      logic              saturated;
   } distance_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;     // innovation, gene_weight, group_size
   logic [1:0]  req_tuser  = '0;     // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;           // excess_count, disjoint_count, weight_diff_avg,
                                     // distance, zero pad
   logic        rsp_tuser;           // saturated
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   genome_compatibility_distance #(.MAX_GENES(MAX_GENES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predictor state: both gene stores and the coefficients
   logic [WORD_W-1:0]        first_innov  [MAX_GENES];
   logic signed [WORD_W-1:0] first_wt     [MAX_GENES];
   logic [WORD_W-1:0]        second_innov [MAX_GENES];
   logic signed [WORD_W-1:0] second_wt    [MAX_GENES];
   int unsigned              first_len  = 0;
   int unsigned              second_len = 0;
   logic [WORD_W-1:0]        coef_excess   = EXCESS_COEFF_RST;
   logic [WORD_W-1:0]        coef_disjoint = DISJOINT_COEFF_RST;
   logic [WORD_W-1:0]        coef_weight   = WEIGHT_COEFF_RST;

   distance_result_type expected_distances [$];
   distance_result_type want;
   int                  errors     = 0;
   int                  items_sent = 0;
   int                  rsp_hold   = 0;
   bit                  quiet      = 1'b0;   // no idling on either side

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run
   initial begin
      #50_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Store one gene, drop it when the store is full
   function automatic void store_gene(input bit to_second, input logic [WORD_W-1:0] innov,
                                      input logic [WORD_W-1:0] wt);
      if (!to_second && first_len < MAX_GENES) begin
         first_innov[first_len] = innov;
         first_wt[first_len]    = wt;
         first_len++;
      end else if (to_second && second_len < MAX_GENES) begin
         second_innov[second_len] = innov;
         second_wt[second_len]    = wt;
         second_len++;
      end
   endfunction

   // Merge-walk both stores, form the distance, then empty the stores
   function automatic distance_result_type predict_distance(
      input logic [WORD_W-1:0] group_field);
      int unsigned         i1, i2, excess, disjoint, avg, divisor;
      int                  diff;
      longint unsigned     c1, c2, c3, num, total;
      distance_result_type r;
      i1 = 0;
      i2 = 0;
      disjoint = 0;
      avg = 0;
      while (i1 < first_len && i2 < second_len) begin
         if (first_innov[i1] == second_innov[i2]) begin
            diff = int'(first_wt[i1]) - int'(second_wt[i2]);
            if (diff < 0) diff = -diff;
            avg = (avg == 0) ? int'(diff) : (int'(diff) + avg) >> 1;
            i1++;
            i2++;
         end else if (first_innov[i1] < second_innov[i2]) begin
            while (i1 < first_len && first_innov[i1] < second_innov[i2]) begin
               disjoint++;
               i1++;
            end
         end else begin
            while (i2 < second_len && second_innov[i2] < first_innov[i1]) begin
               disjoint++;
               i2++;
            end
         end
      end
      excess  = (i1 < first_len) ? first_len - i1 : second_len - i2;
      divisor = (group_field == 0) ? 1 : group_field;
      c1 = coef_excess;
      c2 = coef_disjoint;
      c3 = coef_weight;
      num   = c1 * excess + c2 * disjoint;
      total = num / divisor + ((c3 * avg) >> 8);
      r.saturated = (total > DIST_MAX);
      if (r.saturated) total = DIST_MAX;
      r.excess_count    = excess[6:0];
      r.disjoint_count  = disjoint[7:0];
      r.weight_diff_avg = avg[15:0];
      r.distance        = total[DIST_W-1:0];
      first_len  = 0;
      second_len = 0;
      return r;
   endfunction

   function automatic void check_field(input string name, input longint unsigned exp_val,
                                       input longint unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         errors++;
      end
   endfunction

   function automatic logic [WORD_W-1:0] pick_weight();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Result side: random stall per beat, compare against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_tready && rsp_tvalid) begin
         if (expected_distances.size() == 0) begin
            $error("result beat with no expectation pending");
            errors++;
         end else begin
            want = expected_distances.pop_front();
            check_field("excess_count", want.excess_count, rsp_tdata[6:0]);
            check_field("disjoint_count", want.disjoint_count, rsp_tdata[14:7]);
            check_field("weight_diff_avg", want.weight_diff_avg, rsp_tdata[30:15]);
            check_field("distance", want.distance, rsp_tdata[54:31]);
            check_field("saturated", want.saturated, rsp_tuser);
         end
         rsp_hold = quiet ? 0 : $urandom_range(0, 16);
         if (rsp_hold != 0) rsp_tready <= 1'b0;
      end else if (!rsp_tready) begin
         if (rsp_hold == 0) rsp_tready <= 1'b1;
         else rsp_hold--;
      end
   end

   // Send one input beat after a random gap; predict on acceptance
   task automatic send_beat(input mode_type mode, input logic [WORD_W-1:0] innovation,
                            input logic [WORD_W-1:0] gene_weight,
                            input logic [WORD_W-1:0] group_size);
      int                  gap;
      distance_result_type exp_r;
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {group_size, gene_weight, innovation};
      do @(posedge clock); while (!req_tready);
      case (mode)
         MODE_LOAD_FIRST:  store_gene(1'b0, innovation, gene_weight);
         MODE_LOAD_SECOND: store_gene(1'b1, innovation, gene_weight);
         MODE_COMPUTE: begin
            exp_r = predict_distance(group_size);
            expected_distances = {expected_distances, exp_r};
         end
         default: ;
      endcase
      if (mode != MODE_UNUSED) items_sent++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_distances.size() != 0);
   endtask

   // Coefficients change only with the block idle
   task automatic set_coefficients(input logic [WORD_W-1:0] c1, input logic [WORD_W-1:0] c2,
                                   input logic [WORD_W-1:0] c3);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_EXCESS_COEFF;
      csr_wdata <= c1;
      @(posedge clock);
      coef_excess = c1;
      csr_index <= CSR_DISJOINT_COEFF;
      csr_wdata <= c2;
      @(posedge clock);
      coef_disjoint = c2;
      csr_index <= CSR_WEIGHT_COEFF;
      csr_wdata <= c3;
      @(posedge clock);
      coef_weight = c3;
      csr_we <= 1'b0;
   endtask

   task automatic test_directed_cases();
      // compute on empty stores with a zero group size
      send_beat(MODE_COMPUTE, 16'hFFFF, 16'hFFFF, 16'd0);
      // unused mode changes nothing
      send_beat(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // extreme innovations and weights, largest weight difference
      send_beat(MODE_LOAD_FIRST, 16'h0000, 16'h8000, 16'd1);
      send_beat(MODE_LOAD_SECOND, 16'h0000, 16'h7FFF, 16'd1);
      send_beat(MODE_LOAD_FIRST, 16'hFFFF, 16'h7FFF, 16'hFFFF);
      send_beat(MODE_LOAD_SECOND, 16'hFFFF, 16'h8000, 16'd0);
      send_beat(MODE_COMPUTE, 16'h0000, 16'h0000, 16'd1);
      // disjoint runs on both sides plus excess
      send_beat(MODE_LOAD_FIRST, 16'd1, 16'h0100, 16'd0);
      send_beat(MODE_LOAD_FIRST, 16'd2, 16'h0200, 16'd0);
      send_beat(MODE_LOAD_FIRST, 16'd5, 16'hFF00, 16'd0);
      send_beat(MODE_LOAD_FIRST, 16'd9, 16'h0000, 16'd0);
      send_beat(MODE_LOAD_SECOND, 16'd2, 16'h0180, 16'd0);
      send_beat(MODE_LOAD_SECOND, 16'd3, 16'h0000, 16'd0);
      send_beat(MODE_LOAD_SECOND, 16'd4, 16'h0000, 16'd0);
      send_beat(MODE_LOAD_SECOND, 16'd5, 16'h0100, 16'd0);
      send_beat(MODE_COMPUTE, 16'd0, 16'd0, 16'd3);
      // unsorted stores
      send_beat(MODE_LOAD_FIRST, 16'd5, 16'h0040, 16'd0);
      send_beat(MODE_LOAD_FIRST, 16'd1, 16'hFFC0, 16'd0);
      send_beat(MODE_LOAD_SECOND, 16'd1, 16'h0300, 16'd0);
      send_beat(MODE_LOAD_SECOND, 16'd5, 16'h0010, 16'd0);
      send_beat(MODE_COMPUTE, 16'd0, 16'd0, 16'hFFFF);
      // equal weights give a zero difference
      send_beat(MODE_LOAD_FIRST, 16'd7, 16'h1234, 16'd0);
      send_beat(MODE_LOAD_SECOND, 16'd7, 16'h1234, 16'd0);
      send_beat(MODE_COMPUTE, 16'd0, 16'd0, 16'd2);
   endtask

   task automatic test_saturation();
      set_coefficients(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(MODE_LOAD_FIRST, 16'd10, 16'h8000, 16'd0);
      send_beat(MODE_LOAD_FIRST, 16'd20, 16'h0000, 16'd0);
      send_beat(MODE_LOAD_SECOND, 16'd10, 16'h7FFF, 16'd0);
      send_beat(MODE_COMPUTE, 16'd0, 16'd0, 16'd1);
   endtask

   // One pair of genomes with random content, then a compute beat
   task automatic run_genome_pair();
      gene_beat_type first_q [$];
      gene_beat_type second_q [$];
      gene_beat_type b;
      int            vals [$];
      int            span, step_max, value, lift, roll;
      bit            unsorted, noisy;
      unsorted = ($urandom_range(0, 9) == 0);
      noisy    = ($urandom_range(0, 7) == 0);
      span     = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 12);
      case ($urandom_range(0, 2))
         0:       step_max = 1;
         1:       step_max = 4;
         default: step_max = 400;
      endcase
      // ascending innovations unless unsorted, sometimes pushed up to the top of the range
      value = $urandom_range(0, 65535 - span * step_max);
      for (int k = 0; k < span; k++) begin
         if (k > 0) value += $urandom_range(1, step_max);
         vals = {vals, (unsorted ? int'($urandom_range(0, 15)) : value)};
      end
      if (!unsorted && span > 0 && $urandom_range(0, 3) == 0) begin
         lift = 65535 - vals[span-1];
         foreach (vals[k]) vals[k] += lift;
      end
      // split into shared, first-only and second-only genes
      foreach (vals[k]) begin
         roll = $urandom_range(0, 9);
         b.innovation  = 16'(vals[k]);
         b.gene_weight = pick_weight();
         b.group_size  = 16'($urandom);
         if (roll < 7) begin
            b.mode = MODE_LOAD_FIRST;
            first_q = {first_q, b};
         end
         if (roll < 4 || roll >= 7) begin
            b.mode = MODE_LOAD_SECOND;
            if (roll < 4 && $urandom_range(0, 3) == 0)
               b.gene_weight = b.gene_weight + 16'($urandom_range(0, 3));
            else
               b.gene_weight = pick_weight();
            b.group_size = 16'($urandom);
            second_q = {second_q, b};
         end
      end
      // interleave the two lists, with stray unused beats when noisy
      while (first_q.size() != 0 || second_q.size() != 0) begin
         if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(0, 1) == 1))
            b = first_q.pop_front();
         else
            b = second_q.pop_front();
         send_beat(b.mode, b.innovation, b.gene_weight, b.group_size);
         if (noisy && $urandom_range(0, 5) == 0)
            send_beat(MODE_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
      end
      case ($urandom_range(0, 9))
         0:       b.group_size = 16'd0;
         1, 2:    b.group_size = 16'($urandom);
         default: b.group_size = 16'($urandom_range(1, 8));
      endcase
      send_beat(MODE_COMPUTE, 16'($urandom), 16'($urandom), b.group_size);
   endtask

   task automatic test_random_phases();
      logic [WORD_W-1:0] c1, c2, c3;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin c1 = EXCESS_COEFF_RST; c2 = DISJOINT_COEFF_RST; c3 = WEIGHT_COEFF_RST; end
            1: begin c1 = 16'h0000; c2 = 16'h0000; c3 = 16'h0000; end
            2: begin c1 = 16'hFFFF; c2 = 16'hFFFF; c3 = 16'hFFFF; end
            3: begin c1 = 16'h0001; c2 = 16'h0001; c3 = 16'h0001; end
            default: begin
               c1 = 16'($urandom);
               c2 = 16'($urandom);
               c3 = 16'($urandom);
            end
         endcase
         set_coefficients(c1, c2, c3);
         quiet = (p % 3 == 2);
         while (items_sent < ITEM_TARGET * (p + 1) / 6) begin
            run_genome_pair();
            if ($urandom_range(0, 11) == 0) wait_for_results();
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_saturation();
      test_random_phases();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> genome_compatibility_distance.f
hdl/gcd_pkg.sv
hdl/gcd_ctrl.sv
hdl/gcd_div.sv
hdl/gcd_datapath.sv
hdl/genome_compatibility_distance.sv
dv/genome_compatibility_distance_tb.sv
